// ===== hw/rtl/ffsm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the filament flow stall monitor.
// Depends on nothing; the monitor and the state memory import it.

package ffsm_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned PosW     = 32;
  localparam int unsigned AngW     = 14;
  localparam int unsigned IntvW    = 16;
  localparam int unsigned PosDW    = 16;
  localparam int unsigned CntW     = 4;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SensIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INTERVAL_MS     = 4'd0,
    CFG_MIN_POS_DELTA   = 4'd1,
    CFG_MIN_ANGLE_DELTA = 4'd2,
    CFG_ERROR_LIMIT     = 4'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_CLEAR = 1'b0,
    OP_CHECK = 1'b1
  } opcode_e;

  localparam logic [IntvW-1:0] IntervalReset = 16'd2000;
  localparam logic [PosDW-1:0] MinPosReset   = 16'd21;
  localparam logic [AngW-1:0]  MinAngReset   = 14'd11;
  localparam logic [CntW-1:0]  ErrLimReset   = 4'd2;

  typedef struct packed {
    logic                   opcode;
    logic                   sensor_index;
    logic [TimeW-1:0]       time_ms;
    logic signed [PosW-1:0] extruder_position;
    logic [AngW-1:0]        angle_sample;
  } in_item_t;

  typedef struct packed {
    logic flow_error;
    logic interval_elapsed;
    logic angle_used;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  reg_index;
    logic [CfgDataW-1:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic             first_check;
    logic             first_position;
    logic             moving;
    logic [CntW-1:0]  miss_count;
    logic [AngW-1:0]  last_angle;
    logic [PosW-1:0]  last_position;
    logic [TimeW-1:0] last_time;
  } chan_state_t;

  localparam chan_state_t ChanReset = '{
    first_check:    1'b1,
    first_position: 1'b1,
    moving:         1'b0,
    miss_count:     '0,
    last_angle:     '0,
    last_position:  '0,
    last_time:      '0
  };

  typedef struct packed {
    logic                en;
    logic                clr;
    logic [SensIdxW-1:0] idx;
    chan_state_t         data;
  } state_wr_t;

endpackage

// ===== hw/rtl/ffsm_chan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload per transfer.
// Used for the configuration, input and result channels; no dependencies.

interface ffsm_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// ===== hw/rtl/filament_flow_stall_monitor.sv =====
`timescale 1ns / 1ps
// Filament flow stall monitor: per-sensor jam detection from position and angle.
// Pipeline: an accepted input is registered in the compute stage and its result in
// the output register; both hold while the result channel stalls.
// Throughput: one item per cycle unless the result channel stalls; the state memory
// is read on transfer and written back as the item leaves the compute stage, with
// a bypass for back-to-back items. Reset: configuration returns to defaults and
// every sensor reads as cleared at once through valid bits; there is no clearing
// pass. Depends on ffsm_pkg, ffsm_chan_if and ffsm_state_mem.

module filament_flow_stall_monitor import ffsm_pkg::*; #(
  parameter int unsigned NUM_SENSORS = 2,
  localparam int unsigned IdxW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ffsm_chan_if.sink    cfg_i,
  ffsm_chan_if.sink    in_i,
  ffsm_chan_if.source  out_o
);

  logic [IntvW-1:0] interval_q;
  logic [PosDW-1:0] min_pos_q;
  logic [AngW-1:0]  min_ang_q;
  logic [CntW-1:0]  err_lim_q;

  logic        s1_valid_q;
  logic        s1_in_range_q;
  in_item_t    s1_item_q;
  logic        out_valid_q;
  out_item_t   out_item_q;

  logic        in_ready;
  logic        in_acc;
  logic        in_range;
  logic        out_adv;
  logic        s1_adv;
  logic        s1_check;
  chan_state_t cur_st;
  chan_state_t nxt_st;
  out_item_t   res;
  state_wr_t   wr_req;

  logic [TimeW-1:0]       lt;
  logic [TimeW-1:0]       dt;
  logic                   elapsed;
  logic [PosW-1:0]        old_pos;
  logic signed [PosW:0]   pos_diff;
  logic signed [PosW:0]   pd_lim;
  logic                   moved;
  logic signed [AngW:0]   ang_diff;
  logic signed [AngW:0]   ad_lim;
  logic                   miss;
  logic [CntW-1:0]        cnt_inc;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= IntervalReset;
      min_pos_q  <= MinPosReset;
      min_ang_q  <= MinAngReset;
      err_lim_q  <= ErrLimReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.reg_index)
        CFG_INTERVAL_MS:     interval_q <= cfg_i.payload.wdata[IntvW-1:0];
        CFG_MIN_POS_DELTA:   min_pos_q  <= cfg_i.payload.wdata[PosDW-1:0];
        CFG_MIN_ANGLE_DELTA: min_ang_q  <= cfg_i.payload.wdata[AngW-1:0];
        CFG_ERROR_LIMIT:     err_lim_q  <= cfg_i.payload.wdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  assign out_adv  = !out_valid_q || out_o.ready;
  assign s1_adv   = s1_valid_q && out_adv;
  assign in_ready = !s1_valid_q || out_adv;
  assign in_acc   = in_i.valid && in_ready;
  assign in_range = (32'(in_i.payload.sensor_index) < NUM_SENSORS);
  assign s1_check = s1_in_range_q && (s1_item_q.opcode == OP_CHECK);

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q     <= in_i.payload;
      s1_in_range_q <= in_range;
    end
    if (out_adv) begin
      out_item_q <= res;
    end
  end

  ffsm_state_mem #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_state_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_acc && in_range),
    .rd_idx_i (IdxW'(in_i.payload.sensor_index)),
    .lk_idx_i (IdxW'(s1_item_q.sensor_index)),
    .wr_i     (wr_req),
    .state_o  (cur_st)
  );

  always_comb begin
    lt       = cur_st.first_check ? s1_item_q.time_ms : cur_st.last_time;
    dt       = s1_item_q.time_ms - lt;
    elapsed  = dt > {{(TimeW-IntvW){1'b0}}, interval_q};
    old_pos  = cur_st.first_position ? s1_item_q.extruder_position
                                     : cur_st.last_position;
    pos_diff = $signed({s1_item_q.extruder_position[PosW-1],
                        s1_item_q.extruder_position})
             - $signed({old_pos[PosW-1], old_pos});
    pd_lim   = $signed({{(PosW+1-PosDW){1'b0}}, min_pos_q});
    moved    = (pos_diff > pd_lim) || (pos_diff < -pd_lim);
    ang_diff = $signed({1'b0, s1_item_q.angle_sample})
             - $signed({1'b0, cur_st.last_angle});
    ad_lim   = $signed({1'b0, min_ang_q});
    miss     = (ang_diff < ad_lim) && (ang_diff > -ad_lim);
    cnt_inc  = cur_st.miss_count + CntW'(1);

    nxt_st             = cur_st;
    nxt_st.first_check = 1'b0;
    nxt_st.last_time   = lt;
    res                = '0;
    if (elapsed) begin
      res.interval_elapsed  = 1'b1;
      nxt_st.first_position = 1'b0;
      nxt_st.last_position  = s1_item_q.extruder_position;
      nxt_st.last_time      = s1_item_q.time_ms;
      if (moved) begin
        res.angle_used    = 1'b1;
        nxt_st.last_angle = s1_item_q.angle_sample;
        nxt_st.moving     = 1'b1;
        if (!cur_st.moving) begin
          nxt_st.miss_count = '0;
        end else if (miss) begin
          if (cnt_inc == err_lim_q) begin
            res.flow_error    = 1'b1;
            nxt_st.miss_count = '0;
          end else begin
            nxt_st.miss_count = cnt_inc;
          end
        end else begin
          nxt_st.miss_count = '0;
        end
      end else begin
        nxt_st.moving = 1'b0;
      end
    end
    if (!s1_check) begin
      res = '0;
    end

    wr_req.en   = s1_adv && s1_in_range_q;
    wr_req.clr  = (s1_item_q.opcode == OP_CLEAR);
    wr_req.idx  = SensIdxW'(s1_item_q.sensor_index);
    wr_req.data = nxt_st;
  end

  ap_err_implies_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.flow_error |->
      out_item_q.angle_used && out_item_q.interval_elapsed)
    else $error("flow error raised without a compared angle");

  ap_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_adv |=> s1_valid_q && $stable(s1_item_q))
    else $error("stalled item lost or changed in the compute stage");

  ap_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !s1_check |=> out_item_q == '0)
    else $error("clear or ignored item produced a non-zero result");

  ap_first_no_elapse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_check && cur_st.first_check |=> !out_item_q.interval_elapsed)
    else $error("first check after a clear reported an elapsed interval");

endmodule

// ===== hw/rtl/ffsm_state_mem.sv =====
`timescale 1ns / 1ps
// Per-sensor state store: synchronous memory with a registered read, valid bits
// and a bypass of the most recent write. Depends on ffsm_pkg.

module ffsm_state_mem import ffsm_pkg::*; #(
  parameter int unsigned NUM_SENSORS = 2,
  localparam int unsigned IdxW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_idx_i,
  input  logic [IdxW-1:0] lk_idx_i,
  input  state_wr_t       wr_i,
  output chan_state_t     state_o
);

  chan_state_t            mem_q [NUM_SENSORS];
  chan_state_t            rd_q;
  chan_state_t            byp_q;
  logic [NUM_SENSORS-1:0] vld_q;
  logic                   byp_vld_q;
  logic [IdxW-1:0]        byp_idx_q;
  logic [IdxW-1:0]        wr_idx;
  logic                   wr_data;

  assign wr_idx  = wr_i.idx[IdxW-1:0];
  assign wr_data = wr_i.en && !wr_i.clr;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_idx_i];
    end
    if (wr_data) begin
      mem_q[wr_idx] <= wr_i.data;
      byp_q         <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      byp_vld_q <= 1'b0;
      byp_idx_q <= '0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_idx] <= !wr_i.clr;
      end
      if (wr_data) begin
        byp_vld_q <= 1'b1;
        byp_idx_q <= wr_idx;
      end
    end
  end

  // A write at the edge of the read is not seen by the memory output.
  always_comb begin
    if (!vld_q[lk_idx_i]) begin
      state_o = ChanReset;
    end else if (byp_vld_q && (byp_idx_q == lk_idx_i)) begin
      state_o = byp_q;
    end else begin
      state_o = rd_q;
    end
  end

endmodule
